FILE: hdl/mbe_pkg.sv
// shared types and constants for the mfm byte encoder with crc
// no dependencies
`timescale 1ns / 1ps

package mbe_pkg;

  localparam int MAX_REPEAT_DEF = 64;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [7:0]  MARK_BYTE = 8'hA1;
  // data bit in front of which the mark drops its clock bit
  localparam int          MARK_SUP_POS = 2;

  typedef enum logic [1:0] {
    OP_DATA  = 2'd0,
    OP_MARK  = 2'd1,
    OP_TRACK = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_EMIT
  } state_t;

endpackage

FILE: hdl/mfm_byte_encoder_with_crc_top.sv
// mfm byte encoder with running crc-16-ccitt, bit-serial datapath
// depends on mbe_pkg
`timescale 1ns / 1ps

// Usage
//   s_axis carries one request: a data byte with a repeat count, an A1
//   address mark, or a track start (kind in tuser). m_axis delivers one
//   16-bit cell word and the running crc per byte copy; tlast marks the
//   final word of a request. cfg_valid/cfg_data write encoding_mode; the user
//   must do so only while the block is idle (not enforced); cfg_ready is high outside reset.
// Timing
//   each copy is sent through an 8-bit shift path, one bit per cycle,
//   which drives the crc and, for the first copy of a request, the
//   clock/data cell builder; a copy then waits in the emit state until the
//   output register is free and is loaded into it. The input is held
//   until the last word of a request is registered; a track start or an
//   unused kind is taken without a word.
// Stall
//   the output register holds a word until taken; the next request is
//   accepted in the cycle after the last word of the current one is
//   registered, and a finished copy waits in place while the receiver stalls.
// Reset
//   rst (synchronous) clears the last data bit, sets the crc to 0xFFFF,
//   selects mode 0 and empties the output register; no request or
//   register write is taken while rst is high.

module mfm_byte_encoder_with_crc_top #(
  parameter int MAX_REPEAT = mbe_pkg::MAX_REPEAT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // data_byte[7:0], repeat_req[14:8], zero pad
  input  logic [1:0]  s_axis_tuser,  // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // cell_word[15:0], crc_value[31:16]
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data
);
  import mbe_pkg::*;

  localparam int NMAX  = (MAX_REPEAT < 127) ? MAX_REPEAT : 127;
  localparam int CNT_W = (NMAX > 1) ? $clog2(NMAX + 1) : 1;

  state_t state, state_next;

  logic [1:0]       mode;
  logic             prev;
  logic [15:0]      crc;
  logic [7:0]       sh;
  logic [7:0]       clk_sr;
  logic [7:0]       dat_sr;
  logic [2:0]       bitcnt;
  logic [CNT_W-1:0] left;
  logic             first;
  logic             mark;

  logic       accept;
  logic       load;
  logic       out_free;
  logic       interleaved;
  logic       simple;
  logic       bit_in;
  logic       clk_bit;
  logic       fb;
  logic [6:0] rep_sat;
  logic [15:0] word;
  op_t        op_in;
  logic [6:0] rep_in;

  assign cfg_ready   = ~rst;
  assign interleaved = ~mode[1];
  assign simple      = (mode == 2'd3);
  assign op_in       = op_t'(s_axis_tuser);
  assign rep_in      = s_axis_tdata[14:8];
  assign accept      = s_axis_tvalid & s_axis_tready;
  assign out_free    = ~m_axis_tvalid | m_axis_tready;

  assign bit_in = sh[7];
  assign fb     = crc[15] ^ bit_in;
  always_comb begin
    if (simple) begin
      clk_bit = mark;
    end else begin
      clk_bit = ~bit_in & ~prev & ~(mark && bitcnt == 3'(7 - MARK_SUP_POS));
    end
  end

  always_comb begin
    if (rep_in == 7'd0) begin
      rep_sat = 7'd1;
    end else if (rep_in > 7'(NMAX)) begin
      rep_sat = 7'(NMAX);
    end else begin
      rep_sat = rep_in;
    end
  end

  // clock bits at odd positions, data bits at even ones (interleaved modes only)
  always_comb begin
    if (interleaved) begin
      for (int j = 0; j < 8; j++) begin
        word[2*j+1] = clk_sr[j];
        word[2*j]   = dat_sr[j];
      end
    end else begin
      word = {clk_sr, dat_sr};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    load          = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = ~rst;
        if (s_axis_tvalid && (op_in == OP_DATA || op_in == OP_MARK)) begin
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (bitcnt == 3'd7) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = (left == '0) ? ST_IDLE : ST_SHIFT;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= 2'd0;
      prev  <= 1'b0;
      crc   <= CRC_INIT;
      first <= 1'b0;
      mark  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        mode <= cfg_data;
      end
      if (accept) begin
        unique case (op_in)
          OP_DATA: begin
            mark  <= 1'b0;
            first <= 1'b1;
          end
          OP_MARK: begin
            mark  <= 1'b1;
            first <= 1'b1;
            crc   <= CRC_INIT;
          end
          OP_TRACK: prev <= 1'b0;
          default: ;
        endcase
      end else if (state == ST_SHIFT) begin
        crc <= {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        if (first) begin
          prev <= bit_in;
        end
      end else if (load) begin
        first <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sh     <= (op_in == OP_MARK) ? MARK_BYTE : s_axis_tdata[7:0];
      bitcnt <= 3'd0;
      left   <= (op_in == OP_MARK) ? '0 : CNT_W'(rep_sat - 7'd1);
    end else if (state == ST_SHIFT) begin
      sh     <= {sh[6:0], sh[7]};
      bitcnt <= bitcnt + 3'd1;
      if (first) begin
        clk_sr <= {clk_sr[6:0], clk_bit};
        dat_sr <= {dat_sr[6:0], bit_in};
      end
    end else if (load && left != '0) begin
      left   <= left - CNT_W'(1);
      bitcnt <= 3'd0;
      // later interleaved copies: top clock bit follows the byte's own last bit
      if (interleaved) begin
        clk_sr[7] <= ~sh[7] & ~prev;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= {crc, word};
      m_axis_tlast <= (left == '0);
    end
  end

  a_mark_single: assert property (@(posedge clk) disable iff (rst)
    (accept && op_in == OP_MARK) |=> (state == ST_SHIFT && left == '0 && crc == CRC_INIT))
    else $error("mark request must yield a single word from a fresh crc");

  a_track_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && op_in == OP_TRACK) |=> (!prev && state == ST_IDLE))
    else $error("track start must clear the last data bit");

  a_shift_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT && bitcnt == 3'd7) |=> (state == ST_EMIT && sh == $past(
      {sh[6:0], sh[7]})))
    else $error("copy shift must end after eight bits");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (load && left == '0) |=> (state == ST_IDLE && m_axis_tvalid && m_axis_tlast))
    else $error("last word must return the block to idle");

endmodule

FILE: dv/tb_mfm_byte_encoder_with_crc_top.sv
// self-checking testbench for the mfm byte encoder with running crc-16-ccitt
// predicts cell words, crc and tlast per byte copy; depends on mbe_pkg and the top level
`timescale 1ns / 1ps

module tb_mfm_byte_encoder_with_crc_top;
  import mbe_pkg::*;

  localparam int          MAX_COPIES = MAX_REPEAT_DEF;
  localparam logic [1:0]  OP_UNUSED = 2'd3;
  localparam logic [1:0]  MODE_CELLS = 2'd0;
  localparam logic [1:0]  MODE_CELLS_ALT = 2'd1;
  localparam logic [1:0]  MODE_SPLIT = 2'd2;
  localparam logic [1:0]  MODE_SPLIT_SIMPLE = 2'd3;
  localparam logic [7:0]  GAP_BYTE = 8'h4E;
  localparam logic [7:0]  SYNC_BYTE = 8'h00;
  localparam logic [7:0]  ID_MARK = 8'hFE;
  localparam logic [7:0]  DATA_MARK = 8'hFB;
  localparam logic [7:0]  DELETED_MARK = 8'hF8;

  typedef struct packed {
    logic [15:0] cell_word;
    logic [15:0] crc_value;
    logic        last_word;
  } cell_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // data_byte[7:0], repeat_req[14:8], zero pad
  logic [1:0]  s_axis_tuser = '0;  // op[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;       // cell_word[15:0], crc_value[31:16]
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data = '0;

  // predictor state
  logic [1:0]   mode_reg = MODE_CELLS;
  logic         last_data_bit = 1'b0;
  logic [15:0]  crc_reg = CRC_INIT;
  cell_result_t expected_words[$];

  int error_count = 0;
  int items_sent = 0;
  int burst_left = 0;
  int rx_count = 0;

  mfm_byte_encoder_with_crc_top uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] crc_after_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) c = (c << 1) ^ CRC_POLY;
      else c = c << 1;
    end
    return c;
  endfunction

  // works out the cell words one accepted request causes
  task automatic predict_cell_words(logic [1:0] op, logic [7:0] data_byte,
                                    logic [6:0] repeat_req);
    logic [7:0]   b;
    logic [7:0]   sup;
    logic         mark;
    logic         clock_bit;
    logic         interleaved;
    int           copies;
    logic [15:0]  word;
    cell_result_t res;
    interleaved = (mode_reg == MODE_CELLS) || (mode_reg == MODE_CELLS_ALT);
    if (op == OP_TRACK) begin
      last_data_bit = 1'b0;
      return;
    end
    if (op == OP_UNUSED) return;
    mark = (op == OP_MARK);
    if (mark) begin
      crc_reg = CRC_INIT;
      b = MARK_BYTE;
      sup = 8'h01 << MARK_SUP_POS;
      copies = 1;
    end else begin
      b = data_byte;
      sup = 8'h00;
      copies = (repeat_req == 0) ? 1 : int'(repeat_req);
      if (copies > MAX_COPIES) copies = MAX_COPIES;
    end
    crc_reg = crc_after_byte(crc_reg, b);
    word = '0;
    for (int i = 7; i >= 0; i--) begin
      clock_bit = 1'b0;
      if (b[i]) begin
        last_data_bit = 1'b1;
      end else begin
        if (!last_data_bit && mode_reg != MODE_SPLIT_SIMPLE && !sup[i]) clock_bit = 1'b1;
        last_data_bit = 1'b0;
      end
      if (mode_reg == MODE_SPLIT_SIMPLE && mark) clock_bit = 1'b1;
      if (interleaved) begin
        word[2*i+1] = clock_bit;
        word[2*i] = b[i];
      end else begin
        word[8+i] = clock_bit;
        word[i] = b[i];
      end
    end
    res.cell_word = word;
    res.crc_value = crc_reg;
    res.last_word = (copies == 1);
    expected_words.push_back(res);
    // later interleaved copies follow the byte's own last bit
    if (interleaved) word[15] = !b[7] && !last_data_bit;
    for (int k = 1; k < copies; k++) begin
      crc_reg = crc_after_byte(crc_reg, b);
      res.cell_word = word;
      res.crc_value = crc_reg;
      res.last_word = (k == copies - 1);
      expected_words.push_back(res);
    end
  endtask

  // sends one request in bursts with random gaps
  task automatic send_request(logic [1:0] op, logic [7:0] data_byte, logic [6:0] repeat_req);
    int gap;
    if (burst_left == 0) begin
      gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, repeat_req, data_byte};
    s_axis_tuser <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_cell_words(op, data_byte, repeat_req);
    burst_left--;
    items_sent++;
  endtask

  // waits for the block to drain, then writes the mode register
  task automatic set_mode(logic [1:0] mode);
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_words.size() != 0) @(posedge clk);
    // track start or unused kind may still be in flight
    repeat (16) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mode_reg = mode;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [6:0] pick_repeat();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 7'($urandom_range(0, 3));
    if (r < 9) return 7'($urandom_range(4, 20));
    return 7'($urandom_range(21, 127));
  endfunction

  task automatic send_marks();
    int marks;
    marks = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 3;
    repeat (marks) send_request(OP_MARK, 8'($urandom()), 7'($urandom()));
  endtask

  // one id field and one data field with random content
  task automatic send_sector();
    if ($urandom_range(0, 3) == 0) send_request(OP_TRACK, 8'($urandom()), 7'($urandom()));
    send_request(OP_DATA, GAP_BYTE, 7'($urandom_range(8, 40)));
    send_request(OP_DATA, SYNC_BYTE, 7'($urandom_range(6, 12)));
    send_marks();
    send_request(OP_DATA, ID_MARK, 7'd1);
    repeat (6) send_request(OP_DATA, 8'($urandom()), 7'd1);
    send_request(OP_DATA, GAP_BYTE, 7'($urandom_range(8, 22)));
    send_request(OP_DATA, SYNC_BYTE, 7'd12);
    send_marks();
    send_request(OP_DATA, ($urandom_range(0, 3) == 0) ? DELETED_MARK : DATA_MARK, 7'd1);
    repeat ($urandom_range(4, 16))
      send_request(OP_DATA, 8'($urandom()),
                   ($urandom_range(0, 4) == 0) ? 7'($urandom_range(2, 4)) : 7'd1);
    repeat (2) send_request(OP_DATA, 8'($urandom()), 7'd1);
  endtask

  task automatic test_directed();
    // mode 0 from reset
    send_request(OP_DATA, 8'h00, 7'd0);
    send_request(OP_DATA, 8'hFF, 7'd1);
    send_request(OP_DATA, 8'h00, 7'd3);
    send_request(OP_MARK, 8'h37, 7'd5);  // repeat ignored on a mark
    send_request(OP_MARK, 8'hFF, 7'd127);
    send_request(OP_MARK, 8'h00, 7'd0);
    send_request(OP_DATA, 8'hFE, 7'd1);
    send_request(OP_DATA, 8'h80, 7'd2);
    send_request(OP_DATA, 8'h01, 7'd2);
    send_request(OP_DATA, 8'h55, 7'd64);
    send_request(OP_DATA, 8'hAA, 7'd127);  // saturates
    send_request(OP_DATA, GAP_BYTE, 7'd65);
    send_request(OP_TRACK, 8'hFF, 7'd127);
    send_request(OP_UNUSED, 8'hFF, 7'd127);
    send_request(OP_DATA, 8'h00, 7'd1);
    set_mode(MODE_SPLIT_SIMPLE);
    send_request(OP_MARK, 8'h00, 7'd0);
    send_request(OP_DATA, 8'h00, 7'd2);
    send_request(OP_DATA, 8'hFF, 7'd1);
    set_mode(MODE_SPLIT);
    send_request(OP_DATA, 8'h00, 7'd3);
    send_request(OP_MARK, 8'h00, 7'd1);
    send_request(OP_DATA, 8'h7F, 7'd2);
  endtask

  task automatic test_formatted_track(logic [1:0] mode, int count);
    int start;
    set_mode(mode);
    start = items_sent;
    while (items_sent - start < count) send_sector();
  endtask

  task automatic test_noise(logic [1:0] mode, int count);
    set_mode(mode);
    repeat (count)
      send_request(2'($urandom_range(0, 3)), 8'($urandom()), pick_repeat());
  endtask

  // receiver: long stretches ready, others stalling at random
  always @(posedge clk) begin
    cell_result_t exp_word;
    rx_count <= rx_count + 1;
    m_axis_tready <= rx_count[10] ? 1'b1 : ($urandom_range(0, 2) != 0);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected cell word %h", m_axis_tdata[15:0]);
        error_count++;
      end else begin
        exp_word = expected_words.pop_front();
        if (m_axis_tdata[15:0] !== exp_word.cell_word) begin
          $error("cell_word expected %h actual %h", exp_word.cell_word, m_axis_tdata[15:0]);
          error_count++;
        end
        if (m_axis_tdata[31:16] !== exp_word.crc_value) begin
          $error("crc_value expected %h actual %h", exp_word.crc_value, m_axis_tdata[31:16]);
          error_count++;
        end
        if (m_axis_tlast !== exp_word.last_word) begin
          $error("last_word expected %b actual %b", exp_word.last_word, m_axis_tlast);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_formatted_track(MODE_CELLS_ALT, 85);
    test_noise(MODE_CELLS_ALT, 25);
    test_formatted_track(MODE_SPLIT_SIMPLE, 85);
    test_noise(MODE_SPLIT_SIMPLE, 25);
    test_formatted_track(MODE_CELLS, 85);
    test_noise(MODE_CELLS, 25);
    test_formatted_track(MODE_SPLIT, 85);
    test_noise(MODE_SPLIT, 25);
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: files.f
hdl/mbe_pkg.sv
hdl/mfm_byte_encoder_with_crc_top.sv
dv/tb_mfm_byte_encoder_with_crc_top.sv
